FILE: sv/i2csmb_pkg.sv
// i2csmb_pkg: types and constants shared by the I2C slave mailbox buffer.
// No dependencies.
package i2csmb_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned FILL_W = 6;
  localparam int unsigned ACT_W  = 2;

  localparam logic [ACT_W-1:0] ACT_BUS   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_TX = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RD_RX = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLR   = 2'd3;

  localparam logic [BYTE_W-1:0] STS_SLA_W     = 8'h60;
  localparam logic [BYTE_W-1:0] STS_SLA_W_ARB = 8'h68;
  localparam logic [BYTE_W-1:0] STS_RX_DATA   = 8'h80;
  localparam logic [BYTE_W-1:0] STS_STOP      = 8'hA0;
  localparam logic [BYTE_W-1:0] STS_SLA_R     = 8'hA8;
  localparam logic [BYTE_W-1:0] STS_SLA_R_ARB = 8'hB0;
  localparam logic [BYTE_W-1:0] STS_TX_ACKED  = 8'hB8;
  localparam logic [BYTE_W-1:0] STS_TX_NACKED = 8'hC0;
  localparam logic [BYTE_W-1:0] STS_TX_LAST   = 8'hC8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

FILE: sv/i2csmb_ctrl.sv
// i2csmb_ctrl: sequencing state machine of the mailbox buffer.
// Depends on i2csmb_pkg.
module i2csmb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output logic             done_o,
  output i2csmb_pkg::ctrl_t ctrl_o
);

  i2csmb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2csmb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    busy_o      = 1'b0;
    done_o      = 1'b0;
    ctrl_o.load = 1'b0;
    ctrl_o.exec = 1'b0;
    unique case (state_q)
      i2csmb_pkg::ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = i2csmb_pkg::ST_EXEC;
        end
      end
      i2csmb_pkg::ST_EXEC: begin
        busy_o      = 1'b1;
        ctrl_o.exec = 1'b1;
        state_d     = i2csmb_pkg::ST_RESP;
      end
      i2csmb_pkg::ST_RESP: begin
        done_o = 1'b1;
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = i2csmb_pkg::ST_EXEC;
        end else begin
          state_d = i2csmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i2csmb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/i2csmb_dp.sv
// i2csmb_dp: stores, pointers, flag and result registers of the mailbox buffer.
// Depends on i2csmb_pkg; driven by i2csmb_ctrl.
module i2csmb_dp #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  i2csmb_pkg::ctrl_t                 ctrl_i,
  input  logic [i2csmb_pkg::ACT_W-1:0]      action_i,
  input  logic [i2csmb_pkg::BYTE_W-1:0]     status_i,
  input  logic [i2csmb_pkg::BYTE_W-1:0]     bus_byte_i,
  input  logic [i2csmb_pkg::IDX_W-1:0]      host_index_i,
  input  logic [i2csmb_pkg::BYTE_W-1:0]     host_byte_i,
  output logic                              send_valid_o,
  output logic [i2csmb_pkg::BYTE_W-1:0]     send_byte_o,
  output logic                              rearm_ack_o,
  output logic [i2csmb_pkg::BYTE_W-1:0]     read_byte_o,
  output logic                              received_flag_o,
  output logic [i2csmb_pkg::FILL_W-1:0]     rx_fill_o
);

  localparam int unsigned PW = (BUF_DEPTH > 2) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned IW = (PW > i2csmb_pkg::IDX_W) ? PW : i2csmb_pkg::IDX_W;
  localparam int unsigned FW = (PW > i2csmb_pkg::FILL_W) ? PW : i2csmb_pkg::FILL_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(BUF_DEPTH - 1);

  logic [i2csmb_pkg::ACT_W-1:0]  action_q;
  logic [i2csmb_pkg::BYTE_W-1:0] status_q;
  logic [i2csmb_pkg::BYTE_W-1:0] bus_byte_q;
  logic [i2csmb_pkg::IDX_W-1:0]  host_index_q;
  logic [i2csmb_pkg::BYTE_W-1:0] host_byte_q;

  logic [i2csmb_pkg::BYTE_W-1:0] rx_mem [BUF_DEPTH];
  logic [i2csmb_pkg::BYTE_W-1:0] tx_mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0]          rx_vld_q;
  logic [BUF_DEPTH-1:0]          tx_vld_q;

  logic [PW-1:0] rx_ptr_q, rx_ptr_d;
  logic [PW-1:0] tx_ptr_q, tx_ptr_d;
  logic          flag_q, flag_d;

  logic [i2csmb_pkg::BYTE_W-1:0] rx_rd_q, tx_rd_q;
  logic                          rx_hit_q, tx_hit_q;
  logic                          send_q, rearm_q, rd_q;

  logic [IW-1:0] idx_ext;
  logic [PW-1:0] host_addr;
  logic          host_ok;
  logic          rx_wr, tx_wr, host_rd, send, rearm;
  logic [PW-1:0] tx_addr;
  logic [FW-1:0] fill_ext;

  assign idx_ext   = IW'(host_index_q);
  assign host_addr = idx_ext[PW-1:0];
  assign host_ok   = (int'(host_index_q) < int'(BUF_DEPTH));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      action_q     <= action_i;
      status_q     <= status_i;
      bus_byte_q   <= bus_byte_i;
      host_index_q <= host_index_i;
      host_byte_q  <= host_byte_i;
    end
  end

  always_comb begin
    rx_ptr_d = rx_ptr_q;
    tx_ptr_d = tx_ptr_q;
    flag_d   = flag_q;
    rx_wr    = 1'b0;
    tx_wr    = 1'b0;
    host_rd  = 1'b0;
    send     = 1'b0;
    rearm    = 1'b0;
    tx_addr  = tx_ptr_q;
    unique case (action_q)
      i2csmb_pkg::ACT_BUS: begin
        unique case (status_q) inside
          i2csmb_pkg::STS_SLA_W, i2csmb_pkg::STS_SLA_W_ARB: begin
            rx_ptr_d = '0;
            rearm    = 1'b1;
          end
          i2csmb_pkg::STS_RX_DATA: begin
            rx_wr    = 1'b1;
            rx_ptr_d = (rx_ptr_q == PTR_LAST) ? '0 : rx_ptr_q + 1'b1;
            rearm    = 1'b1;
          end
          i2csmb_pkg::STS_STOP: begin
            flag_d = 1'b1;
            rearm  = 1'b1;
          end
          i2csmb_pkg::STS_SLA_R, i2csmb_pkg::STS_SLA_R_ARB: begin
            tx_addr  = '0;
            send     = 1'b1;
            tx_ptr_d = PW'(1 % BUF_DEPTH);
            rearm    = 1'b1;
          end
          i2csmb_pkg::STS_TX_ACKED: begin
            send     = 1'b1;
            tx_ptr_d = (tx_ptr_q == PTR_LAST) ? '0 : tx_ptr_q + 1'b1;
            rearm    = 1'b1;
          end
          i2csmb_pkg::STS_TX_NACKED, i2csmb_pkg::STS_TX_LAST: begin
            rearm = 1'b1;
          end
          default: begin
            rearm = 1'b0;
          end
        endcase
      end
      i2csmb_pkg::ACT_WR_TX: begin
        tx_wr = host_ok;
      end
      i2csmb_pkg::ACT_RD_RX: begin
        host_rd = 1'b1;
      end
      i2csmb_pkg::ACT_CLR: begin
        flag_d = 1'b0;
      end
      default: begin
        flag_d = flag_q;
      end
    endcase
  end

  // store arrays: one write and one registered read per transfer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      if (rx_wr) begin
        rx_mem[rx_ptr_q] <= bus_byte_q;
      end
      if (tx_wr) begin
        tx_mem[host_addr] <= host_byte_q;
      end
      rx_rd_q  <= rx_mem[host_addr];
      rx_hit_q <= host_ok && rx_vld_q[host_addr];
      tx_rd_q  <= tx_mem[tx_addr];
      tx_hit_q <= tx_vld_q[tx_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_vld_q <= '0;
      tx_vld_q <= '0;
      rx_ptr_q <= '0;
      tx_ptr_q <= '0;
      flag_q   <= 1'b0;
      send_q   <= 1'b0;
      rearm_q  <= 1'b0;
      rd_q     <= 1'b0;
    end else if (ctrl_i.exec) begin
      if (rx_wr) begin
        rx_vld_q[rx_ptr_q] <= 1'b1;
      end
      if (tx_wr) begin
        tx_vld_q[host_addr] <= 1'b1;
      end
      rx_ptr_q <= rx_ptr_d;
      tx_ptr_q <= tx_ptr_d;
      flag_q   <= flag_d;
      send_q   <= send;
      rearm_q  <= rearm;
      rd_q     <= host_rd;
    end
  end

  assign fill_ext        = FW'(rx_ptr_q);
  assign send_valid_o    = send_q;
  assign send_byte_o     = (send_q && tx_hit_q) ? tx_rd_q : '0;
  assign rearm_ack_o     = rearm_q;
  assign read_byte_o     = (rd_q && rx_hit_q) ? rx_rd_q : '0;
  assign received_flag_o = flag_q;
  assign rx_fill_o       = fill_ext[i2csmb_pkg::FILL_W-1:0];

endmodule

FILE: sv/i2c_slave_mailbox_buffer.sv
// i2c_slave_mailbox_buffer: slave-side mailbox of an I2C controller.
// done_o strobes in ST_RESP; ST_EXEC is entered at the accepting edge.
// A new transfer can start while done_o is high; busy covers ST_EXEC,
// in which each store takes one write and one registered read.
// Reset: pointers, received flag and store entry valid bits clear at once;
// entries never written read as zero. Results cannot be stalled.
module i2c_slave_mailbox_buffer #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  output logic                          done_o,
  input  logic [i2csmb_pkg::ACT_W-1:0]  action_i,
  input  logic [i2csmb_pkg::BYTE_W-1:0] status_i,
  input  logic [i2csmb_pkg::BYTE_W-1:0] bus_byte_i,
  input  logic [i2csmb_pkg::IDX_W-1:0]  host_index_i,
  input  logic [i2csmb_pkg::BYTE_W-1:0] host_byte_i,
  output logic                          send_valid_o,
  output logic [i2csmb_pkg::BYTE_W-1:0] send_byte_o,
  output logic                          rearm_ack_o,
  output logic [i2csmb_pkg::BYTE_W-1:0] read_byte_o,
  output logic                          received_flag_o,
  output logic [i2csmb_pkg::FILL_W-1:0] rx_fill_o
);

  i2csmb_pkg::ctrl_t ctrl;

  i2csmb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .ctrl_o  (ctrl)
  );

  i2csmb_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .action_i        (action_i),
    .status_i        (status_i),
    .bus_byte_i      (bus_byte_i),
    .host_index_i    (host_index_i),
    .host_byte_i     (host_byte_i),
    .send_valid_o    (send_valid_o),
    .send_byte_o     (send_byte_o),
    .rearm_ack_o     (rearm_ack_o),
    .read_byte_o     (read_byte_o),
    .received_flag_o (received_flag_o),
    .rx_fill_o       (rx_fill_o)
  );

endmodule

FILE: verif/tb_i2c_slave_mailbox_buffer.sv
// tb_i2c_slave_mailbox_buffer: self-checking testbench for the I2C slave mailbox buffer.
// Directed and random bus/host transfers are checked against a cycle-free mailbox predictor.
// Depends on i2csmb_pkg and i2c_slave_mailbox_buffer.
module tb_i2c_slave_mailbox_buffer;

  localparam int unsigned BYTE_W      = i2csmb_pkg::BYTE_W;
  localparam int unsigned IDX_W       = i2csmb_pkg::IDX_W;
  localparam int unsigned FILL_W      = i2csmb_pkg::FILL_W;
  localparam int unsigned ACT_W       = i2csmb_pkg::ACT_W;
  localparam int unsigned DEPTH       = 64;
  localparam int unsigned N_RANDOM    = 1600;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 8;

  typedef struct packed {
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              rearm_ack;
    logic [BYTE_W-1:0] read_byte;
    logic              received_flag;
    logic [FILL_W-1:0] rx_fill;
  } mbx_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              done_o;
  logic [ACT_W-1:0]  action_i;
  logic [BYTE_W-1:0] status_i;
  logic [BYTE_W-1:0] bus_byte_i;
  logic [IDX_W-1:0]  host_index_i;
  logic [BYTE_W-1:0] host_byte_i;
  logic              send_valid_o;
  logic [BYTE_W-1:0] send_byte_o;
  logic              rearm_ack_o;
  logic [BYTE_W-1:0] read_byte_o;
  logic              received_flag_o;
  logic [FILL_W-1:0] rx_fill_o;

  // predictor state
  logic [BYTE_W-1:0] rx_mem [DEPTH];
  logic [BYTE_W-1:0] tx_mem [DEPTH];
  logic [FILL_W-1:0] rx_ptr;
  logic [IDX_W-1:0]  tx_ptr;
  logic              rx_done;

  mbx_result_t pending_results[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned n_sent;
  bit          gaps_on;

  i2c_slave_mailbox_buffer #(
    .BUF_DEPTH(DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .done_o         (done_o),
    .action_i       (action_i),
    .status_i       (status_i),
    .bus_byte_i     (bus_byte_i),
    .host_index_i   (host_index_i),
    .host_byte_i    (host_byte_i),
    .send_valid_o   (send_valid_o),
    .send_byte_o    (send_byte_o),
    .rearm_ack_o    (rearm_ack_o),
    .read_byte_o    (read_byte_o),
    .received_flag_o(received_flag_o),
    .rx_fill_o      (rx_fill_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  function automatic mbx_result_t predict_mailbox(input logic [ACT_W-1:0] act,
                                                  input logic [BYTE_W-1:0] sts,
                                                  input logic [BYTE_W-1:0] bb,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [BYTE_W-1:0] hb);
    mbx_result_t res;
    res = '0;
    // pointers are 6 bits wide, so +1 wraps exactly at DEPTH
    case (act)
      i2csmb_pkg::ACT_BUS: begin
        case (sts)
          i2csmb_pkg::STS_SLA_W, i2csmb_pkg::STS_SLA_W_ARB: begin
            rx_ptr        = '0;
            res.rearm_ack = 1'b1;
          end
          i2csmb_pkg::STS_RX_DATA: begin
            rx_mem[rx_ptr] = bb;
            rx_ptr         = rx_ptr + 1'b1;
            res.rearm_ack  = 1'b1;
          end
          i2csmb_pkg::STS_STOP: begin
            rx_done       = 1'b1;
            res.rearm_ack = 1'b1;
          end
          i2csmb_pkg::STS_SLA_R, i2csmb_pkg::STS_SLA_R_ARB: begin
            res.send_valid = 1'b1;
            res.send_byte  = tx_mem[0];
            tx_ptr         = IDX_W'(1);
            res.rearm_ack  = 1'b1;
          end
          i2csmb_pkg::STS_TX_ACKED: begin
            res.send_valid = 1'b1;
            res.send_byte  = tx_mem[tx_ptr];
            tx_ptr         = tx_ptr + 1'b1;
            res.rearm_ack  = 1'b1;
          end
          i2csmb_pkg::STS_TX_NACKED, i2csmb_pkg::STS_TX_LAST: res.rearm_ack = 1'b1;
          default: ;
        endcase
      end
      i2csmb_pkg::ACT_WR_TX: tx_mem[idx] = hb;
      i2csmb_pkg::ACT_RD_RX: res.read_byte = rx_mem[idx];
      default: rx_done = 1'b0;
    endcase
    res.received_flag = rx_done;
    res.rx_fill       = rx_ptr;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no transfer outstanding");
      end else begin
        mbx_result_t want;
        want = pending_results.pop_front();
        if (send_valid_o !== want.send_valid)
          report_mismatch($sformatf("send_valid got %b exp %b", send_valid_o, want.send_valid));
        if (send_byte_o !== want.send_byte)
          report_mismatch($sformatf("send_byte got %h exp %h", send_byte_o, want.send_byte));
        if (rearm_ack_o !== want.rearm_ack)
          report_mismatch($sformatf("rearm_ack got %b exp %b", rearm_ack_o, want.rearm_ack));
        if (read_byte_o !== want.read_byte)
          report_mismatch($sformatf("read_byte got %h exp %h", read_byte_o, want.read_byte));
        if (received_flag_o !== want.received_flag)
          report_mismatch($sformatf("received_flag got %b exp %b",
                                    received_flag_o, want.received_flag));
        if (rx_fill_o !== want.rx_fill)
          report_mismatch($sformatf("rx_fill got %0d exp %0d", rx_fill_o, want.rx_fill));
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start        = 1'b0;
      action_i     = ACT_W'($urandom);
      status_i     = BYTE_W'($urandom);
      bus_byte_i   = BYTE_W'($urandom);
      host_index_i = IDX_W'($urandom);
      host_byte_i  = BYTE_W'($urandom);
    end
  endtask

  task automatic send_xfer(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] sts,
                           input logic [BYTE_W-1:0] bb, input logic [IDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] hb);
    @(negedge clk_i);
    start        = 1'b1;
    action_i     = act;
    status_i     = sts;
    bus_byte_i   = bb;
    host_index_i = idx;
    host_byte_i  = hb;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_results.push_back(predict_mailbox(act, sts, bb, idx, hb));
    n_sent++;
    idle_cycles(gap_len());
  endtask

  task automatic bus_evt(input logic [BYTE_W-1:0] sts, input logic [BYTE_W-1:0] bb);
    send_xfer(i2csmb_pkg::ACT_BUS, sts, bb, IDX_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic host_wr(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] hb);
    send_xfer(i2csmb_pkg::ACT_WR_TX, BYTE_W'($urandom), BYTE_W'($urandom), idx, hb);
  endtask

  task automatic host_rd(input logic [IDX_W-1:0] idx);
    send_xfer(i2csmb_pkg::ACT_RD_RX, BYTE_W'($urandom), BYTE_W'($urandom), idx,
              BYTE_W'($urandom));
  endtask

  task automatic clear_flag();
    send_xfer(i2csmb_pkg::ACT_CLR, BYTE_W'($urandom), BYTE_W'($urandom), IDX_W'($urandom),
              BYTE_W'($urandom));
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_reads();
    host_rd('0);
    host_rd('1);
  endtask

  task automatic test_rx_path();
    bus_evt(i2csmb_pkg::STS_SLA_W, 8'h00);
    bus_evt(i2csmb_pkg::STS_RX_DATA, 8'hFF);
    bus_evt(i2csmb_pkg::STS_RX_DATA, 8'h00);
    bus_evt(i2csmb_pkg::STS_SLA_W_ARB, 8'h11);
    bus_evt(i2csmb_pkg::STS_RX_DATA, 8'hA5);
    host_rd(IDX_W'(0));
    host_rd(IDX_W'(1));
  endtask

  task automatic test_tx_path();
    host_wr(IDX_W'(0), 8'hFF);
    host_wr('1, 8'h00);
    host_wr(IDX_W'(1), 8'h5A);
    bus_evt(i2csmb_pkg::STS_SLA_R, 8'h00);
    bus_evt(i2csmb_pkg::STS_TX_ACKED, 8'h00);
    bus_evt(i2csmb_pkg::STS_SLA_R_ARB, 8'hFF);
    bus_evt(i2csmb_pkg::STS_TX_ACKED, 8'hFF);
  endtask

  task automatic test_flag();
    bus_evt(i2csmb_pkg::STS_STOP, 8'h00);
    bus_evt(i2csmb_pkg::STS_TX_NACKED, 8'h00);
    bus_evt(i2csmb_pkg::STS_TX_LAST, 8'h00);
    clear_flag();
  endtask

  task automatic test_unknown_status();
    bus_evt(8'h00, 8'hFF);
    bus_evt(8'hFF, 8'h00);
    bus_evt(8'h81, 8'h3C);
  endtask

  task automatic master_write();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
    bus_evt($urandom_range(0, 1) ? i2csmb_pkg::STS_SLA_W : i2csmb_pkg::STS_SLA_W_ARB,
            BYTE_W'($urandom));
    repeat (n) bus_evt(i2csmb_pkg::STS_RX_DATA, BYTE_W'($urandom));
    if ($urandom_range(0, 4) != 0) bus_evt(i2csmb_pkg::STS_STOP, BYTE_W'($urandom));
  endtask

  task automatic master_read();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
    bus_evt($urandom_range(0, 1) ? i2csmb_pkg::STS_SLA_R : i2csmb_pkg::STS_SLA_R_ARB,
            BYTE_W'($urandom));
    repeat (n) bus_evt(i2csmb_pkg::STS_TX_ACKED, BYTE_W'($urandom));
    if ($urandom_range(0, 4) != 0)
      bus_evt($urandom_range(0, 1) ? i2csmb_pkg::STS_TX_NACKED : i2csmb_pkg::STS_TX_LAST,
              BYTE_W'($urandom));
    if ($urandom_range(0, 2) == 0) bus_evt(i2csmb_pkg::STS_STOP, BYTE_W'($urandom));
  endtask

  task automatic noise();
    logic [BYTE_W-1:0] codes [10];
    codes = '{i2csmb_pkg::STS_SLA_W, i2csmb_pkg::STS_SLA_W_ARB, i2csmb_pkg::STS_RX_DATA,
              i2csmb_pkg::STS_STOP, i2csmb_pkg::STS_SLA_R, i2csmb_pkg::STS_SLA_R_ARB,
              i2csmb_pkg::STS_TX_ACKED, i2csmb_pkg::STS_TX_NACKED, i2csmb_pkg::STS_TX_LAST,
              8'h00};
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1))
        bus_evt(codes[$urandom_range(0, 9)], BYTE_W'($urandom));
      else
        send_xfer(ACT_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  IDX_W'($urandom), BYTE_W'($urandom));
    end
  endtask

  task automatic test_random();
    int unsigned r;
    bit          drained;
    drained = 1'b0;
    while (n_sent < N_RANDOM) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      r       = $urandom_range(0, 99);
      if (r < 30) master_write();
      else if (r < 55) master_read();
      else if (r < 70) repeat ($urandom_range(1, 8)) host_wr(IDX_W'($urandom), BYTE_W'($urandom));
      else if (r < 85) repeat ($urandom_range(1, 8)) host_rd(IDX_W'($urandom));
      else if (r < 90) clear_flag();
      else noise();
      if (!drained && n_sent > N_RANDOM / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    action_i     = i2csmb_pkg::ACT_BUS;
    status_i     = '0;
    bus_byte_i   = '0;
    host_index_i = '0;
    host_byte_i  = '0;
    err_cnt      = 0;
    n_sent       = 0;
    gaps_on      = 1'b1;
    rx_ptr       = '0;
    tx_ptr       = '0;
    rx_done      = 1'b0;
    foreach (rx_mem[i]) rx_mem[i] = '0;
    foreach (tx_mem[i]) tx_mem[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_reads();
    test_rx_path();
    test_tx_path();
    test_flag();
    test_unknown_status();
    wait_drained();
    test_random();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
